// File: rtl/bdpc_pkg.sv
// Shared types and constants for the button debounce / press classifier.
// No dependencies; imported by every module of the block.
package bdpc_pkg;

   // Default count of buttons served by one block
   localparam int NUM_BUTTONS_DEF = 3;

   // Field and register widths
   localparam int BUTTON_W  = 2;
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int MASK_W    = 3;
   localparam int CSR_IDX_W = 3;

   // Register reset values
   localparam logic [CFG_W-1:0]  DEBOUNCE_RST   = 16'd30;
   localparam logic [CFG_W-1:0]  LONG_PRESS_RST = 16'd3000;
   localparam logic [CFG_W-1:0]  REP_DELAY_RST  = 16'd400;
   localparam logic [CFG_W-1:0]  REP_INTVL_RST  = 16'd150;
   localparam logic [MASK_W-1:0] REP_MASK_RST   = 3'd0;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE   = 3'd0,
      CSR_LONG_PRESS = 3'd1,
      CSR_REP_DELAY  = 3'd2,
      CSR_REP_INTVL  = 3'd3,
      CSR_REP_MASK   = 3'd4
   } csr_idx_type;

   // Event codes of a result word
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_REPEAT = 2'd3
   } event_type;

   // Current configuration, handed from the register file to the core
   typedef struct packed {
      logic [CFG_W-1:0]  debounce_time;
      logic [CFG_W-1:0]  long_press_time;
      logic [CFG_W-1:0]  repeat_delay;
      logic [CFG_W-1:0]  repeat_interval;
      logic [MASK_W-1:0] repeat_mask;
   } cfg_type;

endpackage

// File: rtl/bdpc_csr.sv
// Configuration register file for the button classifier.
// Depends on bdpc_pkg for widths, register indexes and reset values.
module bdpc_csr
   import bdpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode a write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_DEBOUNCE:   cfg_in.debounce_time   = csr_wdata;
            CSR_LONG_PRESS: cfg_in.long_press_time = csr_wdata;
            CSR_REP_DELAY:  cfg_in.repeat_delay    = csr_wdata;
            CSR_REP_INTVL:  cfg_in.repeat_interval = csr_wdata;
            CSR_REP_MASK:   cfg_in.repeat_mask     = csr_wdata[MASK_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= DEBOUNCE_RST;
         cfg_ff.long_press_time <= LONG_PRESS_RST;
         cfg_ff.repeat_delay    <= REP_DELAY_RST;
         cfg_ff.repeat_interval <= REP_INTVL_RST;
         cfg_ff.repeat_mask     <= REP_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/bdpc_core.sv
// Per-button state and the single-pass debounce / press classification.
// Depends on bdpc_pkg for the config struct and event codes.
module bdpc_core
   import bdpc_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [BUTTON_W-1:0] button,
   input  logic                level,
   input  logic [TIME_W-1:0]   now_ms,
   input  cfg_type             cfg,
   output event_type           event_res,
   output logic                held
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   // Per-button state, one entry per button
   logic              acc_lvl_ff  [NUM_BUTTONS];
   logic [TIME_W-1:0] chg_time_ff [NUM_BUTTONS];
   logic              pressed_ff  [NUM_BUTTONS];
   logic [TIME_W-1:0] press_ff    [NUM_BUTTONS];
   logic              long_ff     [NUM_BUTTONS];
   logic [TIME_W-1:0] rep_time_ff [NUM_BUTTONS];

   logic              acc_lvl_in, pressed_in, long_in;
   logic [TIME_W-1:0] chg_time_in, press_in, rep_time_in;

   logic              in_range;
   logic [IDX_W-1:0]  idx;
   logic              rep_mode;
   logic [MASK_W:0]   mask_ext;
   logic [TIME_W-1:0] since_chg, dur, hold, since_rep;
   logic              take, done;
   event_type         ev;

   assign in_range = (int'(button) < NUM_BUTTONS);
   assign idx      = IDX_W'(button);
   // Buttons without a mask bit run in plain mode
   assign mask_ext = {1'b0, cfg.repeat_mask};
   assign rep_mode = mask_ext[button];

   // Classification of one sample against the selected button's state
   always_comb begin
      acc_lvl_in  = acc_lvl_ff[idx];
      chg_time_in = chg_time_ff[idx];
      pressed_in  = pressed_ff[idx];
      press_in    = press_ff[idx];
      long_in     = long_ff[idx];
      rep_time_in = rep_time_ff[idx];
      ev          = EV_NONE;
      done        = 1'b0;

      since_chg = now_ms - chg_time_ff[idx];
      dur       = now_ms - press_ff[idx];
      take      = (level != acc_lvl_ff[idx]) &&
                  (since_chg >= TIME_W'(cfg.debounce_time));

      // Accepted level change
      if (take) begin
         chg_time_in = now_ms;
         acc_lvl_in  = level;
         if (!level) begin
            press_in    = now_ms;
            rep_time_in = now_ms;
            pressed_in  = 1'b1;
            long_in     = 1'b0;
         end else begin
            pressed_in = 1'b0;
            if (!long_ff[idx]) begin
               if (rep_mode) begin
                  if (dur < TIME_W'(cfg.repeat_delay)) begin
                     ev   = EV_SHORT;
                     done = 1'b1;
                  end
               end else begin
                  ev   = (dur >= TIME_W'(cfg.long_press_time)) ? EV_LONG : EV_SHORT;
                  done = 1'b1;
               end
            end
         end
      end

      // Hold handling on the updated state
      hold      = now_ms - press_in;
      since_rep = now_ms - rep_time_in;
      if (!done && pressed_in && !long_in) begin
         if (rep_mode) begin
            if (hold >= TIME_W'(cfg.repeat_delay) &&
                since_rep >= TIME_W'(cfg.repeat_interval)) begin
               rep_time_in = now_ms;
               ev          = EV_REPEAT;
            end
         end else if (hold >= TIME_W'(cfg.long_press_time)) begin
            long_in = 1'b1;
            ev      = EV_LONG;
         end
      end
   end

   // State write-back on each processed word of an in-range button
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            acc_lvl_ff[i]  <= 1'b1;
            chg_time_ff[i] <= '0;
            pressed_ff[i]  <= 1'b0;
            press_ff[i]    <= '0;
            long_ff[i]     <= 1'b0;
            rep_time_ff[i] <= '0;
         end
      end else if (fire && in_range) begin
         acc_lvl_ff[idx]  <= acc_lvl_in;
         chg_time_ff[idx] <= chg_time_in;
         pressed_ff[idx]  <= pressed_in;
         press_ff[idx]    <= press_in;
         long_ff[idx]     <= long_in;
         rep_time_ff[idx] <= rep_time_in;
      end
   end

   // Out-of-range button: no event, not held
   assign event_res = in_range ? ev : EV_NONE;
   assign held      = in_range & pressed_in;

endmodule

// File: rtl/button_debounce_press_classifier.sv
// Button debounce and short / long / repeat press classifier, top level.
// The request word is held in the input register, and its result is loaded into the
// result register once that register is empty or being taken (rsp_ready high).
// One word per cycle unless rsp_ready stalls; per-button state updates at that load.
// Reset (synchronous, active high) restores register defaults, all buttons released,
// and empties both pipeline registers. Depends on bdpc_pkg, bdpc_csr and bdpc_core.
module button_debounce_press_classifier
   import bdpc_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BUTTON_W-1:0]  req_button,
   input  logic                 req_level,
   input  logic [TIME_W-1:0]    req_now_ms,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_event_res,
   output logic                 rsp_held,
   // configuration port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type cfg;

   logic                in_valid_ff, in_valid_in;
   logic [BUTTON_W-1:0] button_ff;
   logic                level_ff;
   logic [TIME_W-1:0]   now_ff;

   logic                out_valid_ff, out_valid_in;
   event_type           event_ff;
   logic                held_ff;

   event_type           core_event;
   logic                core_held;
   logic                out_free, fire, req_take;

   bdpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdpc_core #(.NUM_BUTTONS(NUM_BUTTONS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .button    (button_ff),
      .level     (level_ff),
      .now_ms    (now_ff),
      .cfg       (cfg),
      .event_res (core_event),
      .held      (core_held)
   );

   // Handshake: result register frees when empty or being taken
   assign out_free     = !out_valid_ff || rsp_ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || fire;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input word register
   always_ff @(posedge clock) begin
      if (req_take) begin
         button_ff <= req_button;
         level_ff  <= req_level;
         now_ff    <= req_now_ms;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (fire) begin
         event_ff <= core_event;
         held_ff  <= core_held;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = event_ff;
   assign rsp_held      = held_ff;

endmodule

// File: tb/button_debounce_press_classifier_tb.sv
// Self-checking testbench for button_debounce_press_classifier: directed table, random phases.
// A local predictor of the debounce / press logic checks words that no table row types.
// Depends on bdpc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb
   import bdpc_pkg::*;
();

   localparam int NUM_BTN     = NUM_BUTTONS_DEF;
   localparam int NUM_DIR     = 29;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 200;

   // index with no register behind it, must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 3'd5;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      event_type ev;
      logic      held;
   } press_result_type;

   typedef struct {
      row_kind_type         kind;
      logic [BUTTON_W-1:0]  button;
      logic                 level;
      logic [TIME_W-1:0]    now_ms;
      logic                 typed;   // expectation given in the row
      event_type            ev;
      logic                 held;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CFG_W-1:0]     csr_val;
   } directed_row_type;

   // DUT ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BUTTON_W-1:0]  req_button = '0;
   logic                 req_level = 1'b1;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_event_res;
   logic                 rsp_held;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // predictor copy of the registers and the per-button state
   logic [CFG_W-1:0]     cfg_debounce;
   logic [CFG_W-1:0]     cfg_long;
   logic [CFG_W-1:0]     cfg_delay;
   logic [CFG_W-1:0]     cfg_interval;
   logic [MASK_W-1:0]    cfg_mask;
   logic                 lvl_acc    [NUM_BTN];
   logic [TIME_W-1:0]    t_change   [NUM_BTN];
   logic                 is_pressed [NUM_BTN];
   logic [TIME_W-1:0]    t_press    [NUM_BTN];
   logic                 long_fired [NUM_BTN];
   logic [TIME_W-1:0]    t_repeat   [NUM_BTN];

   press_result_type     pending_presses [$];
   directed_row_type     dir_rows [NUM_DIR];
   logic                 raw_lvl [NUM_BTN];
   int                   mismatch_count = 0;
   int                   stall_cycles = 0;
   bit                   idle_on = 1'b1;
   bit                   hold_request = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   button_debounce_press_classifier u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_button    (req_button),
      .req_level     (req_level),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_held      (rsp_held),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Debounce and classify one sample; updates the predictor state
   function automatic press_result_type classify_sample(input logic [BUTTON_W-1:0] b,
                                                        input logic lvl,
                                                        input logic [TIME_W-1:0] now);
      press_result_type r;
      logic             rep;
      logic             fired;
      logic [TIME_W-1:0] dur;
      r.ev  = EV_NONE;
      r.held = 1'b0;
      fired = 1'b0;
      if (int'(b) >= NUM_BTN) return r;   // unknown button: state untouched
      rep = cfg_mask[b];
      // accepted level change
      if (lvl != lvl_acc[b] && (now - t_change[b]) >= 32'(cfg_debounce)) begin
         t_change[b] = now;
         lvl_acc[b]  = lvl;
         if (!lvl) begin
            t_press[b]    = now;
            t_repeat[b]   = now;
            is_pressed[b] = 1'b1;
            long_fired[b] = 1'b0;
         end else begin
            dur = now - t_press[b];
            is_pressed[b] = 1'b0;
            if (!long_fired[b]) begin
               if (rep) begin
                  if (dur < 32'(cfg_delay)) begin
                     r.ev  = EV_SHORT;
                     fired = 1'b1;
                  end
               end else begin
                  r.ev  = (dur >= 32'(cfg_long)) ? EV_LONG : EV_SHORT;
                  fired = 1'b1;
               end
            end
         end
      end
      // events while held
      if (!fired && is_pressed[b] && !long_fired[b]) begin
         dur = now - t_press[b];
         if (rep) begin
            if (dur >= 32'(cfg_delay) && (now - t_repeat[b]) >= 32'(cfg_interval)) begin
               t_repeat[b] = now;
               r.ev = EV_REPEAT;
            end
         end else if (dur >= 32'(cfg_long)) begin
            long_fired[b] = 1'b1;
            r.ev = EV_LONG;
         end
      end
      r.held = is_pressed[b];
      return r;
   endfunction

   function automatic directed_row_type sample_row(input logic [BUTTON_W-1:0] b, input logic l,
                                                   input logic [TIME_W-1:0] n, input logic typed,
                                                   input event_type ev, input logic held);
      directed_row_type row;
      row.kind    = ROW_SAMPLE;
      row.button  = b;
      row.level   = l;
      row.now_ms  = n;
      row.typed   = typed;
      row.ev      = ev;
      row.held    = held;
      row.csr_idx = '0;
      row.csr_val = '0;
      return row;
   endfunction

   function automatic directed_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                                input logic [CFG_W-1:0] val);
      directed_row_type row;
      row = sample_row('0, 1'b1, '0, 1'b0, EV_NONE, 1'b0);
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   // Register write, mirrored into the predictor
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DEBOUNCE:   cfg_debounce = val;
         CSR_LONG_PRESS: cfg_long     = val;
         CSR_REP_DELAY:  cfg_delay    = val;
         CSR_REP_INTVL:  cfg_interval = val;
         CSR_REP_MASK:   cfg_mask     = val[MASK_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Block idle: all words back, pipeline drained
   task automatic wait_idle();
      while (pending_presses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Offer one sample word and record its expected response on accept
   task automatic send_sample(input logic [BUTTON_W-1:0] b, input logic l,
                              input logic [TIME_W-1:0] n, input logic typed,
                              input event_type ev, input logic held);
      press_result_type r;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_button <= b;
      req_level  <= l;
      req_now_ms <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = classify_sample(b, l, n);
      if (typed) begin
         r.ev   = ev;
         r.held = held;
      end
      pending_presses.push_back(r);
   endtask

   // One random phase under a fixed register setting
   task automatic run_phase(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                            input logic [CFG_W-1:0] rd, input logic [CFG_W-1:0] ri,
                            input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] base);
      int unsigned       step_max;
      int unsigned       step;
      int unsigned       sel;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] n;
      logic [BUTTON_W-1:0] b;
      logic              l;
      wait_idle();
      write_reg(CSR_DEBOUNCE, db);
      write_reg(CSR_LONG_PRESS, lp);
      write_reg(CSR_REP_DELAY, rd);
      write_reg(CSR_REP_INTVL, ri);
      write_reg(CSR_REP_MASK, {{(CFG_W-MASK_W){1'b0}}, mask});
      step_max = (int'(lp) + int'(rd) + int'(ri)) / 6 + int'(db) + 2;
      t = base;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // mostly bounces and ordinary gaps, now and then a long jump
         sel = $urandom_range(0, 9);
         if (sel < 4) step = $urandom_range(0, int'(db) / 2 + 2);
         else if (sel < 9) step = $urandom_range(0, step_max);
         else step = $urandom_range(0, 4 * step_max);
         if ($urandom_range(0, 99) < 3) begin
            n = $urandom();   // stray timestamp
         end else begin
            t = t + step;
            n = t;
         end
         if ($urandom_range(0, 99) < 4) begin
            b = 2'd3;
            l = 1'($urandom_range(0, 1));
         end else begin
            b = BUTTON_W'($urandom_range(0, NUM_BTN - 1));
            if ($urandom_range(0, 99) < 20) raw_lvl[b] = ~raw_lvl[b];
            l = raw_lvl[b];
         end
         send_sample(b, l, n, 1'b0, EV_NONE, 1'b0);
      end
      req_valid <= 1'b0;
   endtask

   // Stimulus
   initial begin
      cfg_debounce = DEBOUNCE_RST;
      cfg_long     = LONG_PRESS_RST;
      cfg_delay    = REP_DELAY_RST;
      cfg_interval = REP_INTVL_RST;
      cfg_mask     = REP_MASK_RST;
      for (int i = 0; i < NUM_BTN; i++) begin
         lvl_acc[i]    = 1'b1;
         t_change[i]   = '0;
         is_pressed[i] = 1'b0;
         t_press[i]    = '0;
         long_fired[i] = 1'b0;
         t_repeat[i]   = '0;
         raw_lvl[i]    = 1'b1;
      end
      dir_rows = '{
         // reset defaults: released level, unknown button, bounce rejected
         sample_row(2'd0, 1'b1, 32'd0, 1'b1, EV_NONE, 1'b0),
         sample_row(2'd3, 1'b0, 32'd100, 1'b1, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b0, 32'd10, 1'b1, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b0, 32'd30, 1'b1, EV_NONE, 1'b1),
         sample_row(2'd0, 1'b1, 32'd40, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b1, 32'd100, 1'b1, EV_SHORT, 1'b0),
         // plain long press while held, then silent release
         sample_row(2'd1, 1'b0, 32'd1000, 1'b1, EV_NONE, 1'b1),
         sample_row(2'd1, 1'b0, 32'd4000, 1'b1, EV_LONG, 1'b1),
         sample_row(2'd1, 1'b0, 32'd5000, 1'b1, EV_NONE, 1'b1),
         sample_row(2'd1, 1'b1, 32'd6000, 1'b0, EV_NONE, 1'b0),
         // hold across the timestamp wrap, long press on release
         sample_row(2'd2, 1'b0, 32'hFFFF_FF00, 1'b1, EV_NONE, 1'b1),
         sample_row(2'd2, 1'b1, 32'h0000_0F00, 1'b1, EV_LONG, 1'b0),
         // repeat mode on button 0: repeats, then a quick tap
         csr_row(CSR_REP_MASK, 16'd1),
         sample_row(2'd0, 1'b0, 32'd200, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b0, 32'd599, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b0, 32'd600, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b0, 32'd700, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b0, 32'd750, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b1, 32'd800, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b0, 32'd900, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd0, 1'b1, 32'd1000, 1'b0, EV_NONE, 1'b0),
         // long press in plain mode, then mode switched while still held
         sample_row(2'd1, 1'b0, 32'd10000, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd1, 1'b0, 32'd13000, 1'b1, EV_LONG, 1'b1),
         csr_row(CSR_REP_MASK, 16'd3),
         sample_row(2'd1, 1'b0, 32'd20000, 1'b0, EV_NONE, 1'b0),
         sample_row(2'd1, 1'b1, 32'd20010, 1'b0, EV_NONE, 1'b0),
         // write to a missing register must leave debounce alone
         csr_row(CSR_NO_REG, 16'hFFFF),
         sample_row(2'd2, 1'b0, 32'h0000_1000, 1'b1, EV_NONE, 1'b1),
         sample_row(2'd2, 1'b1, 32'hFFFF_FFFF, 1'b0, EV_NONE, 1'b0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            req_valid <= 1'b0;
            wait_idle();
            write_reg(dir_rows[i].csr_idx, dir_rows[i].csr_val);
         end else begin
            send_sample(dir_rows[i].button, dir_rows[i].level, dir_rows[i].now_ms,
                        dir_rows[i].typed, dir_rows[i].ev, dir_rows[i].held);
         end
      end
      req_valid <= 1'b0;

      // random phases; the first one starts with a long response hold-off
      // that begins only once the block is drained, so the sender fills it
      wait_idle();
      hold_request = 1'b1;
      run_phase(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(50, 800)),
                CFG_W'($urandom_range(20, 300)), CFG_W'($urandom_range(1, 100)),
                MASK_W'($urandom_range(0, 7)), $urandom());
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 3'd7, $urandom());
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0, 32'hFFF0_0000);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, $urandom());
      run_phase(16'hFFFF, CFG_W'($urandom_range(0, 500)), CFG_W'($urandom_range(0, 300)),
                CFG_W'($urandom_range(0, 100)), MASK_W'($urandom_range(0, 7)), $urandom());
      run_phase(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                MASK_W'($urandom_range(0, 7)), $urandom());
      run_phase(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 600)),
                CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 100)),
                MASK_W'($urandom_range(0, 7)), 32'hFFFF_FF00);
      // last phase runs with no idling on either side
      wait_idle();
      idle_on = 1'b0;
      run_phase(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 600)),
                CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 100)),
                MASK_W'($urandom_range(0, 7)), $urandom());

      wait_idle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Response side: random stalls plus one long hold-off
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each response word with the oldest expectation
   always @(posedge clock) begin
      press_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_presses.size() == 0) begin
            $display("%0t: unexpected response word event %0d held %0b",
                     $time, rsp_event_res, rsp_held);
            mismatch_count++;
         end else begin
            exp_r = pending_presses.pop_front();
            if (rsp_event_res !== exp_r.ev) begin
               $display("%0t: event mismatch, expected %0d actual %0d",
                        $time, exp_r.ev, rsp_event_res);
               mismatch_count++;
            end
            if (rsp_held !== exp_r.held) begin
               $display("%0t: held mismatch, expected %0b actual %0b",
                        $time, exp_r.held, rsp_held);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

endmodule

// File: files.f
rtl/bdpc_pkg.sv
rtl/bdpc_csr.sv
rtl/bdpc_core.sv
rtl/button_debounce_press_classifier.sv
tb/button_debounce_press_classifier_tb.sv
